/* rtl/core/rbe_pkg.sv */
// shared types, constants and codes for the ranged bit set engine
// no dependencies; imported by ranged_bitset_engine, rbe_alu and rbe_store
`default_nettype none

package rbe_pkg;

    // store geometry
    localparam int NUM_BITS  = 1024;
    localparam int NUM_WORDS = (NUM_BITS + 31) / 32;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int REL_W     = WORD_AW + 5;

    // arithmetic width: 32-bit signed operands plus headroom for differences
    localparam int ALU_W = 34;

    localparam logic signed [ALU_W-1:0] REL_LAST = ALU_W'(NUM_BITS - 1);
    localparam logic [31:0]             BIT_ONE  = 32'h0000_0001;
    localparam logic [31:0]             BIT_TOP  = 32'h8000_0000;
    localparam logic [31:0]             HIGH_RST = 32'd1023;

    // configuration register indexes
    localparam int            CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_HIGH = 1'b1;

    // item kinds
    typedef enum logic [2:0] {
        K_SET     = 3'd0,
        K_CLEAR   = 3'd1,
        K_TEST    = 3'd2,
        K_FIND    = 3'd3,
        K_OR_WORD = 3'd4,
        K_AND_WORD= 3'd5,
        K_CLR_ALL = 3'd6
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUB_REL,
        S_SUB_SPAN,
        S_SUB_CMP,
        S_DECIDE,
        S_BIT_OP,
        S_WORD_RD,
        S_WORD_OP,
        S_CLR_ALL,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_POS,
        S_DONE
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op                  op;
        logic signed [ALU_W-1:0]  a;
        logic signed [ALU_W-1:0]  b;
    } t_alu_ctl;

    typedef struct packed {
        logic               rd_en;
        logic [WORD_AW-1:0] rd_addr;
        logic               wr_en;
        logic [WORD_AW-1:0] wr_addr;
        logic [31:0]        wr_data;
        logic               clr_all;
    } t_mem_req;

endpackage

`default_nettype wire

/* rtl/core/ranged_bitset_engine.sv */
// ranged bit set engine: sequencer, config registers and output register
// depends on rbe_pkg, rbe_alu, rbe_store
// steps to o_out_valid: set/clear/test run the subtract passes, a decide step and the bit op,
// or/and word read then write the word, refused or empty-range items end at the decide step
// one item at a time: three subtract passes, one store read per word scanned
// reset: synchronous, clears state and store valid bits, bit_low = 0, bit_high = 1023
`default_nettype none

module ranged_bitset_engine (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config port
    input  wire logic                              i_cfg_we,
    input  wire logic [rbe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [31:0]                       i_cfg_data,
    // input beats
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [2:0]                        i_kind,
    input  wire logic signed [31:0]                i_bit_req,
    input  wire logic [4:0]                        i_word_index,
    input  wire logic [31:0]                       i_word_data,
    // result beats
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_found,
    output logic signed [31:0]                     o_position,
    output logic                                   o_range_error
);
    import rbe_pkg::*;

    // lowest set bit of a word (caller guarantees a set bit when it matters)
    function automatic logic [4:0] f_first_set(input logic [31:0] w);
        logic [4:0] idx;
        idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (w[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    t_state r_state, n_state;

    // config registers
    logic signed [31:0] r_bit_low;
    logic signed [31:0] r_bit_high;

    // latched item
    logic [2:0]         r_kind;
    logic signed [31:0] r_req;
    logic [4:0]         r_widx;
    logic [31:0]        r_wdata;

    // intermediate results of the subtract passes
    logic signed [ALU_W-1:0] r_rel;   // req - bit_low
    logic signed [ALU_W-1:0] r_span;  // bit_high - bit_low

    // find-next scan state
    logic [WORD_AW-1:0] r_word;
    logic [REL_W-1:0]   r_rs;
    logic [REL_W-1:0]   r_re;

    // result being built
    logic               r_found;
    logic signed [31:0] r_pos;
    logic               r_err;

    // output register
    logic               r_out_vld;
    logic               r_out_found;
    logic signed [31:0] r_out_pos;
    logic               r_out_err;

    t_alu_ctl                 w_alu_ctl;
    logic signed [ALU_W-1:0]  w_alu_res;
    t_mem_req                 w_mem_req;
    logic [31:0]              w_rd_data;

    logic                     w_accept;
    logic                     w_out_free;

    logic                     w_rel_neg, w_span_neg, w_rel_le_span;
    logic                     w_rel_big, w_too_wide;
    logic                     w_setclr_ok, w_test_ok, w_find_ok;
    logic [REL_W-1:0]         w_rs, w_re;

    logic [31:0]              w_widx_ext;
    logic                     w_widx_ok;
    logic [WORD_AW-1:0]       w_widx_addr;
    logic [WORD_AW-1:0]       w_rel_word;

    logic [31:0]              w_lo_mask, w_hi_mask, w_scan_word;
    logic                     w_scan_hit, w_scan_last;
    logic [4:0]               w_scan_bit;
    logic [31:0]              w_bit_mask;

    rbe_alu u_alu (
        .i_clk (i_clk),
        .i_ctl (w_alu_ctl),
        .o_res (w_alu_res)
    );

    rbe_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mem_req),
        .o_rd_data (w_rd_data)
    );

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_vld || !i_out_stall;

    // word index check and address for the word merges
    assign w_widx_ext  = 32'(i_word_index);
    assign w_widx_ok   = w_widx_ext < 32'(NUM_WORDS);
    assign w_widx_addr = WORD_AW'(32'(r_widx));
    assign w_rel_word  = r_rel[REL_W-1:5];

    // range decisions, valid in S_DECIDE where w_alu_res holds span - rel
    assign w_rel_neg     = r_rel[ALU_W-1];
    assign w_span_neg    = r_span[ALU_W-1];
    assign w_rel_le_span = !w_alu_res[ALU_W-1];
    assign w_rel_big     = r_rel > REL_LAST;
    assign w_too_wide    = r_span > REL_LAST;
    // set/clear needs the full range to fit the store
    assign w_setclr_ok   = !w_too_wide && !w_rel_neg && w_rel_le_span;
    // test sees only the usable part of the range
    assign w_test_ok     = !w_rel_neg && w_rel_le_span && !w_rel_big;
    // search window is max(rel,0) .. min(span, last store bit)
    assign w_find_ok     = !w_span_neg && (w_rel_neg || (w_rel_le_span && !w_rel_big));
    assign w_rs          = w_rel_neg ? '0 : r_rel[REL_W-1:0];
    assign w_re          = w_too_wide ? REL_W'(NUM_BITS - 1) : r_span[REL_W-1:0];

    // scan word masking: trim below the start bit and above the end bit
    assign w_lo_mask   = (r_word == r_rs[REL_W-1:5]) ? ('1 << r_rs[4:0]) : '1;
    assign w_hi_mask   = (r_word == r_re[REL_W-1:5]) ? ~(('1 << r_re[4:0]) << 1) : '1;
    assign w_scan_word = w_rd_data & w_lo_mask & w_hi_mask;
    assign w_scan_hit  = |w_scan_word;
    assign w_scan_bit  = f_first_set(w_scan_word);
    assign w_scan_last = (r_word == r_re[REL_W-1:5]);

    assign w_bit_mask  = BIT_ONE << r_rel[4:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind)
                        K_SET, K_CLEAR, K_TEST, K_FIND: n_state = S_SUB_REL;
                        K_OR_WORD, K_AND_WORD:          n_state = w_widx_ok ? S_WORD_RD : S_DONE;
                        K_CLR_ALL:                      n_state = S_CLR_ALL;
                        default:                        n_state = S_DONE;
                    endcase
                end
            end
            S_SUB_REL:  n_state = S_SUB_SPAN;
            S_SUB_SPAN: n_state = S_SUB_CMP;
            S_SUB_CMP:  n_state = S_DECIDE;
            S_DECIDE: begin
                case (r_kind)
                    K_SET, K_CLEAR: n_state = w_setclr_ok ? S_BIT_OP : S_DONE;
                    K_TEST:         n_state = w_test_ok ? S_BIT_OP : S_DONE;
                    K_FIND:         n_state = w_find_ok ? S_SCAN_RD : S_DONE;
                    default:        n_state = S_DONE;
                endcase
            end
            S_BIT_OP:   n_state = S_DONE;
            S_WORD_RD:  n_state = S_WORD_OP;
            S_WORD_OP:  n_state = S_DONE;
            S_CLR_ALL:  n_state = S_DONE;
            S_SCAN_RD:  n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (w_scan_hit) begin
                    n_state = S_POS;
                end else if (w_scan_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_POS:      n_state = S_DONE;
            S_DONE:     n_state = w_out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath controls per state
    always_comb begin
        w_alu_ctl.op = ALU_ADD;
        w_alu_ctl.a  = '0;
        w_alu_ctl.b  = '0;
        w_mem_req    = '0;
        o_in_stall   = (r_state != S_IDLE);
        case (r_state)
            S_SUB_REL: begin
                // rel = req - bit_low
                w_alu_ctl.op = ALU_SUB;
                w_alu_ctl.a  = {{2{r_req[31]}}, r_req};
                w_alu_ctl.b  = {{2{r_bit_low[31]}}, r_bit_low};
            end
            S_SUB_SPAN: begin
                // span = bit_high - bit_low
                w_alu_ctl.op = ALU_SUB;
                w_alu_ctl.a  = {{2{r_bit_high[31]}}, r_bit_high};
                w_alu_ctl.b  = {{2{r_bit_low[31]}}, r_bit_low};
            end
            S_SUB_CMP: begin
                // sign of span - rel tells whether req is above bit_high
                w_alu_ctl.op = ALU_SUB;
                w_alu_ctl.a  = w_alu_res;
                w_alu_ctl.b  = r_rel;
            end
            S_DECIDE: begin
                w_mem_req.rd_en   = 1'b1;
                w_mem_req.rd_addr = w_rel_word;
            end
            S_BIT_OP: begin
                w_mem_req.wr_addr = w_rel_word;
                case (r_kind)
                    K_SET: begin
                        w_mem_req.wr_en   = 1'b1;
                        w_mem_req.wr_data = w_rd_data | w_bit_mask;
                    end
                    K_CLEAR: begin
                        w_mem_req.wr_en   = 1'b1;
                        w_mem_req.wr_data = w_rd_data & ~w_bit_mask;
                    end
                    default: w_mem_req.wr_en = 1'b0;
                endcase
            end
            S_WORD_RD: begin
                w_mem_req.rd_en   = 1'b1;
                w_mem_req.rd_addr = w_widx_addr;
            end
            S_WORD_OP: begin
                w_mem_req.wr_en   = 1'b1;
                w_mem_req.wr_addr = w_widx_addr;
                case (r_kind)
                    K_OR_WORD: w_mem_req.wr_data = w_rd_data | r_wdata;
                    default:   w_mem_req.wr_data = w_rd_data & r_wdata;
                endcase
            end
            S_CLR_ALL: begin
                w_mem_req.clr_all = 1'b1;
            end
            S_SCAN_RD: begin
                w_mem_req.rd_en   = 1'b1;
                w_mem_req.rd_addr = r_word;
            end
            S_SCAN_CHK: begin
                // position = bit_low + word * 32 + bit
                w_alu_ctl.op = ALU_ADD;
                w_alu_ctl.a  = {{2{r_bit_low[31]}}, r_bit_low};
                w_alu_ctl.b  = ALU_W'({r_word, w_scan_bit});
            end
            default: begin
                w_mem_req = '0;
            end
        endcase
    end

    // control state, config registers, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_bit_low  <= '0;
            r_bit_high <= HIGH_RST;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BIT_LOW:  r_bit_low  <= i_cfg_data;
                    CFG_BIT_HIGH: r_bit_high <= i_cfg_data;
                    default:      r_bit_low  <= r_bit_low;
                endcase
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_kind;
            r_req   <= i_bit_req;
            r_widx  <= i_word_index;
            r_wdata <= i_word_data;
            r_found <= 1'b0;
            r_pos   <= '0;
            r_err   <= 1'b0;
        end
        case (r_state)
            S_SUB_SPAN: r_rel  <= w_alu_res;
            S_SUB_CMP:  r_span <= w_alu_res;
            S_DECIDE: begin
                if ((r_kind == K_SET || r_kind == K_CLEAR) && !w_setclr_ok) begin
                    r_err <= 1'b1;
                end
                r_word <= w_rs[REL_W-1:5];
                r_rs   <= w_rs;
                r_re   <= w_re;
            end
            S_BIT_OP: begin
                if (r_kind == K_TEST) begin
                    r_found <= |(w_rd_data & w_bit_mask);
                end
            end
            S_SCAN_CHK: begin
                if (w_scan_hit) begin
                    r_found <= 1'b1;
                end else if (!w_scan_last) begin
                    r_word <= r_word + 1'b1;
                end
            end
            S_POS: r_pos <= w_alu_res[31:0];
            default: begin
            end
        endcase
        if (r_state == S_DONE && w_out_free) begin
            r_out_found <= r_found;
            r_out_pos   <= r_pos;
            r_out_err   <= r_err;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_found       = r_out_found;
    assign o_position    = r_out_pos;
    assign o_range_error = r_out_err;

endmodule

`default_nettype wire

/* rtl/core/rbe_alu.sv */
// shared add/subtract unit with registered result
// depends on rbe_pkg
`default_nettype none

module rbe_alu (
    input  wire logic                            i_clk,
    input  wire rbe_pkg::t_alu_ctl               i_ctl,
    output logic signed [rbe_pkg::ALU_W-1:0]     o_res
);
    import rbe_pkg::*;

    logic signed [ALU_W-1:0] n_res;
    logic signed [ALU_W-1:0] r_res;

    always_comb begin
        case (i_ctl.op)
            ALU_ADD: n_res = i_ctl.a + i_ctl.b;
            ALU_SUB: n_res = i_ctl.a - i_ctl.b;
            default: n_res = i_ctl.a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

/* rtl/core/rbe_store.sv */
// word store of the bit set: one write port, one registered read port
// per-word valid bits give the all-zero reset and the clear of the whole store
// depends on rbe_pkg
`default_nettype none

module rbe_store (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rbe_pkg::t_mem_req    i_req,
    output logic [31:0]               o_rd_data
);
    import rbe_pkg::*;

    logic [31:0]          r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_vld;
    logic [31:0]          r_rd_q;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_q <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.clr_all) begin
                r_vld <= '0;
            end else if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    // a word never written since reset or clear reads as zero
    assign o_rd_data = r_rd_vld ? r_rd_q : '0;

endmodule

`default_nettype wire

/* rtl/core/rbe_chk.sv */
// port-level checker for the ranged bit set engine, bound to the top level
// no package dependency
`default_nettype none

module rbe_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_found,
    input wire logic [31:0] o_position,
    input wire logic        o_range_error
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_position)
            && $stable(o_found) && $stable(o_range_error)))
        else $error("result beat changed while stalled");

    // a refused set/clear never reports a hit or a position
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_error) |-> (!o_found && o_position == 32'd0))
        else $error("range error beat carries found or position");

    // one item at a time: the input side closes right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while an item is in flight");

    // reset leaves no result pending and the input open
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("state not cleared by reset");

endmodule

bind ranged_bitset_engine rbe_chk u_rbe_chk (.*);

`default_nettype wire
